[hw/rtl/fdtd_pkg.sv]
// shared types, constants and field arithmetic for the 1-D fdtd field core
// depends on nothing; imported by every module of the core
package fdtd_pkg;

  // grid size and widths
  localparam int unsigned Cells  = 16384;
  localparam int unsigned CellW  = $clog2(Cells);
  localparam int unsigned FieldW = 24;
  localparam int unsigned IdxW   = 14;

  typedef logic signed [FieldW-1:0] field_t;
  typedef logic [IdxW-1:0]          idx_t;
  typedef logic [CellW-1:0]         cell_t;

  localparam idx_t   SourceReset = idx_t'(8192);
  localparam field_t FieldMax    = {1'b0, {(FieldW-1){1'b1}}};
  localparam field_t FieldMin    = {1'b1, {(FieldW-1){1'b0}}};
  localparam cell_t  LastCell    = cell_t'(Cells - 1);

  // command queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic {
    CMD_STEP = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_STEP = 1'b0,
    KIND_READ = 1'b1
  } kind_e;

  typedef struct packed {
    cmd_e   cmd;
    field_t pulse;
    idx_t   cell_idx;
  } item_t;

  // index lies inside the grid
  function automatic logic in_range(idx_t i);
    return (32'(i) < Cells);
  endfunction

  // index to memory address
  function automatic cell_t to_cell(idx_t i);
    return cell_t'(i);
  endfunction

  // floor((a - b) / 2), always fits the field width
  function automatic field_t half_diff(field_t a, field_t b);
    logic signed [FieldW:0] d;
    d = $signed({a[FieldW-1], a}) - $signed({b[FieldW-1], b});
    return field_t'(d >>> 1);
  endfunction

  // saturating add at the field range
  function automatic field_t sat_add(field_t a, field_t b);
    logic signed [FieldW:0] s;
    s = $signed({a[FieldW-1], a}) + $signed({b[FieldW-1], b});
    if (s[FieldW] != s[FieldW-1]) begin
      return s[FieldW] ? FieldMin : FieldMax;
    end
    return field_t'(s);
  endfunction

endpackage

[hw/rtl/fdtd_queue.sv]
// short command queue between the front and the back of the fdtd core
// depends on fdtd_pkg
module fdtd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  fdtd_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output fdtd_pkg::item_t pop_item_o
);
  import fdtd_pkg::*;

  item_t            slot_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == QCntW'(QDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_item_o = slot_q[rd_ptr_q];

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[hw/rtl/fdtd_front.sv]
// front end: takes input transfers, classifies them and queues them,
// and holds the source cell register; depends on fdtd_pkg
module fdtd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            command_i,
  input  fdtd_pkg::field_t pulse_sample_i,
  input  fdtd_pkg::idx_t  cell_index_i,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  fdtd_pkg::idx_t  cfg_data_i,
  input  logic            q_full_i,
  input  logic            clearing_i,
  output logic            push_o,
  output fdtd_pkg::item_t push_item_o,
  output fdtd_pkg::idx_t  source_o
);
  import fdtd_pkg::*;

  idx_t source_q;

  // no transfer while the queue is full or the field memories are clearing
  assign in_stall_o = q_full_i || clearing_i;
  assign push_o     = in_valid_i && !in_stall_o;

  // classify the item; a step carries no cell, a read no pulse
  always_comb begin
    push_item_o.cmd      = cmd_e'(command_i);
    push_item_o.pulse    = '0;
    push_item_o.cell_idx = '0;
    case (push_item_o.cmd)
      CMD_STEP: push_item_o.pulse    = pulse_sample_i;
      CMD_READ: push_item_o.cell_idx = cell_index_i;
      default:  push_item_o.pulse    = '0;
    endcase
  end

  // source cell register, always writable
  assign cfg_ready_o = 1'b1;
  assign source_o    = source_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_q <= SourceReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      source_q <= cfg_data_i;
    end
  end

endmodule

[hw/rtl/fdtd_back.sv]
// back end: field memories, clearing pass, one-cell-per-cycle step sweep,
// field read and the result register; depends on fdtd_pkg
module fdtd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  fdtd_pkg::item_t  q_item_i,
  output logic             q_pop_o,
  input  fdtd_pkg::idx_t   source_i,
  output logic             clearing_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             kind_o,
  output fdtd_pkg::field_t e_value_o,
  output fdtd_pkg::field_t h_value_o
);
  import fdtd_pkg::*;

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StSweep = 3'd2;
  localparam logic [2:0] StDrain = 3'd3;
  localparam logic [2:0] StRead  = 3'd4;

  // field memories
  field_t e_mem [Cells];
  field_t h_mem [Cells];

  logic [2:0] state_q, state_d;
  cell_t      idx_q, idx_d;
  field_t     pulse_q, pulse_d;
  logic       rd_ok_q, rd_ok_d;

  logic   rd_en;
  logic   sweep_rd;
  cell_t  rd_addr;
  field_t e_rd_q, h_rd_q;

  logic   e_we, h_we;
  cell_t  e_wa, h_wa;
  field_t e_wd, h_wd;

  // sweep pipeline: stage b sees read data, stage c writes back
  logic   b_vld_q;
  cell_t  b_idx_q;
  field_t hb_prev_q;
  logic   c_vld_q;
  cell_t  c_idx_q;
  field_t c_e_q, c_eprev_q, c_hprev_q;

  field_t low_q [2];
  field_t high_q [2];

  field_t e_upd, e_src, e_new;
  logic   src_hit;

  logic   load_out;
  kind_e  load_kind;
  logic   out_vld_q, out_vld_d;
  kind_e  out_kind_q;
  field_t out_e_q, out_h_q;

  assign clearing_o = (state_q == StClear);

  // sequencer
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    pulse_d   = pulse_q;
    rd_ok_d   = rd_ok_q;
    q_pop_o   = 1'b0;
    rd_en     = 1'b0;
    sweep_rd  = 1'b0;
    rd_addr   = idx_q;
    load_out  = 1'b0;
    load_kind = KIND_STEP;
    case (state_q)
      StClear: begin
        if (idx_q == LastCell) begin
          idx_d   = '0;
          state_d = StIdle;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StIdle: begin
        if (q_valid_i && !out_vld_q) begin
          q_pop_o = 1'b1;
          if (q_item_i.cmd == CMD_STEP) begin
            pulse_d = q_item_i.pulse;
            idx_d   = '0;
            state_d = StSweep;
          end else begin
            rd_en   = 1'b1;
            rd_addr = to_cell(q_item_i.cell_idx);
            rd_ok_d = in_range(q_item_i.cell_idx);
            state_d = StRead;
          end
        end
      end
      StSweep: begin
        rd_en    = 1'b1;
        sweep_rd = 1'b1;
        if (idx_q == LastCell) begin
          state_d = StDrain;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      StDrain: begin
        if (c_vld_q && (c_idx_q == LastCell)) begin
          load_out  = 1'b1;
          load_kind = KIND_STEP;
          state_d   = StIdle;
        end
      end
      StRead: begin
        load_out  = 1'b1;
        load_kind = KIND_READ;
        state_d   = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      idx_q   <= '0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      low_q   <= '{default: '0};
      high_q  <= '{default: '0};
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      b_vld_q <= sweep_rd;
      c_vld_q <= b_vld_q;
      // low edge history takes cell 1 once it is final
      if (b_vld_q && (b_idx_q == cell_t'(1))) begin
        low_q[1] <= low_q[0];
        low_q[0] <= e_new;
      end
      // high edge history takes cell last-1, held in stage c at this point
      if (b_vld_q && (b_idx_q == LastCell)) begin
        high_q[1] <= high_q[0];
        high_q[0] <= c_e_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pulse_q <= pulse_d;
    rd_ok_q <= rd_ok_d;
  end

  // stage b: new electric field of one cell
  assign src_hit = in_range(source_i) && (b_idx_q == to_cell(source_i));

  always_comb begin
    e_upd = sat_add(e_rd_q, half_diff(hb_prev_q, h_rd_q));
    e_src = src_hit ? sat_add(e_upd, pulse_q) : e_upd;
    if (b_idx_q == '0) begin
      e_new = low_q[1];
    end else if (b_idx_q == LastCell) begin
      e_new = high_q[1];
    end else begin
      e_new = e_src;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    b_idx_q <= rd_addr;
    if (b_vld_q) begin
      hb_prev_q <= h_rd_q;
      c_idx_q   <= b_idx_q;
      c_e_q     <= e_new;
      c_eprev_q <= c_e_q;
      c_hprev_q <= hb_prev_q;
    end
  end

  // write port select: clearing pass or stage c write-back
  always_comb begin
    if (state_q == StClear) begin
      e_we = 1'b1;
      h_we = 1'b1;
      e_wa = idx_q;
      h_wa = idx_q;
      e_wd = '0;
      h_wd = '0;
    end else begin
      e_we = c_vld_q;
      h_we = c_vld_q && (c_idx_q != '0);
      e_wa = c_idx_q;
      h_wa = c_idx_q - 1'b1;
      e_wd = c_e_q;
      h_wd = sat_add(c_hprev_q, half_diff(c_eprev_q, c_e_q));
    end
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (e_we) begin
      e_mem[e_wa] <= e_wd;
    end
    if (h_we) begin
      h_mem[h_wa] <= h_wd;
    end
    if (rd_en) begin
      e_rd_q <= e_mem[rd_addr];
      h_rd_q <= h_mem[rd_addr];
    end
  end

  // result register
  always_comb begin
    out_vld_d = out_vld_q;
    if (load_out) begin
      out_vld_d = 1'b1;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_kind_q <= load_kind;
      if ((load_kind == KIND_READ) && rd_ok_q) begin
        out_e_q <= e_rd_q;
        out_h_q <= h_rd_q;
      end else begin
        out_e_q <= '0;
        out_h_q <= '0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign kind_o      = out_kind_q;
  assign e_value_o   = out_e_q;
  assign h_value_o   = out_h_q;

endmodule

[hw/rtl/fdtd_1d_field_update_core.sv]
// top level of the 1-D fdtd field core: front end, command queue, back end
// depends on fdtd_pkg, fdtd_front, fdtd_queue, fdtd_back
//
// channel   direction  handshake                payload
// in        input      in_valid_i / in_stall_o  command_i, pulse_sample_i, cell_index_i
// out       output     out_valid_o / out_stall_i kind_o, e_value_o, h_value_o
// cfg       input      cfg_valid_i / cfg_ready_o cfg_data_i (source cell)
//
// after reset the field memories are cleared, one cell a cycle;
// input transfers wait during that pass, config writes are taken throughout
// a step sweeps every cell once through one read port per memory; a read
// passes through the memory read register and then the result register
// the queue holds two commands, so up to two more are taken while a step runs;
// the next command starts once the result register is empty
module fdtd_1d_field_update_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             command_i,
  input  fdtd_pkg::field_t pulse_sample_i,
  input  fdtd_pkg::idx_t   cell_index_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             kind_o,
  output fdtd_pkg::field_t e_value_o,
  output fdtd_pkg::field_t h_value_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  fdtd_pkg::idx_t   cfg_data_i
);
  import fdtd_pkg::*;

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;
  logic  clearing;
  idx_t  source;

  // accept and classify
  fdtd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .pulse_sample_i (pulse_sample_i),
    .cell_index_i   (cell_index_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .q_full_i       (q_full),
    .clearing_i     (clearing),
    .push_o         (push),
    .push_item_o    (push_item),
    .source_o       (source)
  );

  // decoupling queue
  fdtd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_item_o  (q_item)
  );

  // field engine
  fdtd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .source_i    (source),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .e_value_o   (e_value_o),
    .h_value_o   (h_value_o)
  );

endmodule
